// File: rtl/csb_pkg.sv
// Shared constants and types for the cursor sequence buffer.
`default_nettype none
package csb_pkg;

   localparam int CAPACITY_SLOTS = 32;
   localparam int ITEM_WIDTH     = 32;
   localparam int SLOT_IDX_W     = $clog2(CAPACITY_SLOTS);
   localparam int COUNT_W        = $clog2(CAPACITY_SLOTS + 1);

   localparam int ACTION_W       = 4;
   localparam int ENTRY_W        = 32;
   localparam int INDEX_W        = 5;
   localparam int OUT_ITEM_W     = 32;
   localparam int OUT_COUNT_W    = 6;
   localparam int OUT_CURSOR_W   = 5;

   localparam int REQ_DATA_W     = 48;
   localparam int RSP_DATA_W     = 80;

   localparam logic [ACTION_W-1:0] ACT_START    = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_END      = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_LAST     = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_ADVANCE  = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_RETREAT  = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_INSERT   = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_ATTACH   = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_INSFRONT = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_APPEND   = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_REMFRONT = 4'd10;
   localparam logic [ACTION_W-1:0] ACT_READ     = 4'd11;
   localparam logic [ACTION_W-1:0] ACT_QUERY    = 4'd12;

   typedef enum logic {
      ST_IDLE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                  ins;
      logic                  rem;
      logic [SLOT_IDX_W-1:0] pos;
      logic [ITEM_WIDTH-1:0] entry;
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type          cmd;
      logic [SLOT_IDX_W-1:0] cursor_next;
      logic [COUNT_W-1:0]    count_next;
      logic                  err;
      logic                  rd_en;
   } ctrl_result_type;

endpackage
`default_nettype wire

// File: rtl/csb_cell.sv
// One slot of the list: holds, loads, or takes its neighbor's entry.
`default_nettype none
module csb_cell (
   input  wire logic                          clock,
   input  wire logic [csb_pkg::SLOT_IDX_W-1:0] my_index,
   input  wire csb_pkg::cell_cmd_type          cmd,
   input  wire logic [csb_pkg::ITEM_WIDTH-1:0] left_data,
   input  wire logic [csb_pkg::ITEM_WIDTH-1:0] right_data,
   input  wire logic [csb_pkg::SLOT_IDX_W-1:0] cursor,
   input  wire logic [csb_pkg::SLOT_IDX_W-1:0] read_index,
   output logic      [csb_pkg::ITEM_WIDTH-1:0] data_out,
   output logic      [csb_pkg::ITEM_WIDTH-1:0] cursor_tap,
   output logic      [csb_pkg::ITEM_WIDTH-1:0] read_tap
);
   import csb_pkg::*;

   logic [ITEM_WIDTH-1:0] slot_ff;
   logic [ITEM_WIDTH-1:0] slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (cmd.ins) begin
         if (my_index > cmd.pos) begin
            slot_in = left_data;
         end else if (my_index == cmd.pos) begin
            slot_in = cmd.entry;
         end
      end else if (cmd.rem) begin
         if (my_index >= cmd.pos) begin
            slot_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign data_out   = slot_ff;
   assign cursor_tap = (my_index == cursor)     ? slot_ff : '0;
   assign read_tap   = (my_index == read_index) ? slot_ff : '0;

endmodule
`default_nettype wire

// File: rtl/csb_ctrl.sv
// Decodes one operation into the new cursor, count, error and shift command.
`default_nettype none
module csb_ctrl (
   input  wire logic [csb_pkg::ACTION_W-1:0]   action,
   input  wire logic [csb_pkg::ENTRY_W-1:0]    entry,
   input  wire logic [csb_pkg::INDEX_W-1:0]    index,
   input  wire logic [csb_pkg::COUNT_W-1:0]    count,
   input  wire logic [csb_pkg::SLOT_IDX_W-1:0] cursor,
   output csb_pkg::ctrl_result_type            result
);
   import csb_pkg::*;

   logic                  room;
   logic                  has_item;
   logic [COUNT_W-1:0]    cursor_ext;
   logic [COUNT_W-1:0]    cursor_inc;
   logic [SLOT_IDX_W-1:0] count_slot;

   assign cursor_ext = COUNT_W'(cursor);
   assign cursor_inc = cursor_ext + COUNT_W'(1);
   assign count_slot = count[SLOT_IDX_W-1:0];
   assign room       = count < COUNT_W'(CAPACITY_SLOTS);
   assign has_item   = cursor_ext < count;

   always_comb begin
      result.cmd.ins     = 1'b0;
      result.cmd.rem     = 1'b0;
      result.cmd.pos     = '0;
      result.cmd.entry   = entry[ITEM_WIDTH-1:0];
      result.cursor_next = cursor;
      result.err         = 1'b0;
      result.rd_en       = 1'b0;
      case (action)
         ACT_START: begin
            result.cursor_next = '0;
         end
         ACT_END: begin
            result.cursor_next = (count != '0) ? SLOT_IDX_W'(count - COUNT_W'(1)) : '0;
         end
         ACT_LAST: begin
            result.cursor_next = SLOT_IDX_W'(CAPACITY_SLOTS - 1);
         end
         ACT_ADVANCE: begin
            if (!has_item) begin
               result.err = 1'b1;
            end else if (cursor_inc < count) begin
               result.cursor_next = cursor_inc[SLOT_IDX_W-1:0];
            end
         end
         ACT_RETREAT: begin
            if (cursor != '0) begin
               result.cursor_next = cursor - SLOT_IDX_W'(1);
            end
         end
         ACT_INSERT: begin
            if (!room) begin
               result.err = 1'b1;
            end else begin
               result.cmd.ins     = 1'b1;
               result.cmd.pos     = has_item ? cursor : count_slot;
               result.cursor_next = result.cmd.pos;
            end
         end
         ACT_ATTACH: begin
            if (!room) begin
               result.err = 1'b1;
            end else begin
               result.cmd.ins     = 1'b1;
               result.cmd.pos     = has_item ? cursor_inc[SLOT_IDX_W-1:0] : count_slot;
               result.cursor_next = result.cmd.pos;
            end
         end
         ACT_REMOVE: begin
            if (!has_item) begin
               result.err = 1'b1;
            end else begin
               result.cmd.rem = 1'b1;
               result.cmd.pos = cursor;
            end
         end
         ACT_INSFRONT: begin
            if (!room) begin
               result.err = 1'b1;
            end else begin
               result.cmd.ins     = 1'b1;
               result.cursor_next = '0;
            end
         end
         ACT_APPEND: begin
            if (!room) begin
               result.err = 1'b1;
            end else begin
               result.cmd.ins     = 1'b1;
               result.cmd.pos     = count_slot;
               result.cursor_next = count_slot;
            end
         end
         ACT_REMFRONT: begin
            if (count == '0) begin
               result.err = 1'b1;
            end else begin
               result.cmd.rem     = 1'b1;
               result.cursor_next = '0;
            end
         end
         ACT_READ: begin
            if (COUNT_W'(index) >= count) begin
               result.err = 1'b1;
            end else begin
               result.rd_en = 1'b1;
            end
         end
         ACT_QUERY: begin
         end
         default: begin
            result.err = 1'b1;
         end
      endcase
      result.count_next = result.cmd.ins ? count + COUNT_W'(1) :
                          result.cmd.rem ? count - COUNT_W'(1) : count;
   end

endmodule
`default_nettype wire

// File: rtl/cursor_sequence_buffer_core.sv
// Top level of the cursor sequence buffer: control, row of slot cells, result register.
`default_nettype none
// A fixed list of 32 entries with a cursor, one operation per request transfer and one
// response transfer per operation. The row of slot cells shifts or loads every entry in
// parallel in the accept cycle, and the response register is loaded from the updated row
// in the following cycle; a new request is taken only after the previous response has been
// loaded and while the response side keeps up. Slot contents are not cleared at reset;
// only entries below the count are ever reported.
module cursor_sequence_buffer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: action[3:0], entry[35:4], index[40:36], zero fill.
   input  wire logic [csb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // Fields from bit 0: current_item[31:0], item_valid[32], count[38:33],
   // cursor[43:39], read_data[75:44], error[76], zero fill.
   output logic      [csb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import csb_pkg::*;

   state_type             state_ff;
   state_type             state_in;
   logic [COUNT_W-1:0]    count_ff;
   logic [SLOT_IDX_W-1:0] cursor_ff;
   logic                  err_ff;
   logic                  rd_en_ff;
   logic [SLOT_IDX_W-1:0] index_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  accept;
   logic                  load_rsp;
   ctrl_result_type       ctrl;
   cell_cmd_type          cmd;

   logic [ITEM_WIDTH-1:0] cell_data   [CAPACITY_SLOTS];
   logic [ITEM_WIDTH-1:0] cursor_taps [CAPACITY_SLOTS];
   logic [ITEM_WIDTH-1:0] read_taps   [CAPACITY_SLOTS];
   logic [ITEM_WIDTH-1:0] cursor_word;
   logic [ITEM_WIDTH-1:0] read_word;
   logic                  has_item;

   assign accept = req_tvalid && req_tready;

   csb_ctrl u_ctrl (
      .action (req_tdata[3:0]),
      .entry  (req_tdata[35:4]),
      .index  (req_tdata[40:36]),
      .count  (count_ff),
      .cursor (cursor_ff),
      .result (ctrl)
   );

   always_comb begin
      cmd     = ctrl.cmd;
      cmd.ins = ctrl.cmd.ins && accept;
      cmd.rem = ctrl.cmd.rem && accept;
   end

   for (genvar i = 0; i < CAPACITY_SLOTS; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] left_data;
      logic [ITEM_WIDTH-1:0] right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY_SLOTS - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end
      csb_cell u_cell (
         .clock      (clock),
         .my_index   (SLOT_IDX_W'(i)),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .cursor     (cursor_ff),
         .read_index (index_ff),
         .data_out   (cell_data[i]),
         .cursor_tap (cursor_taps[i]),
         .read_tap   (read_taps[i])
      );
   end

   always_comb begin
      cursor_word = '0;
      read_word   = '0;
      for (int i = 0; i < CAPACITY_SLOTS; i++) begin
         cursor_word = cursor_word | cursor_taps[i];
         read_word   = read_word | read_taps[i];
      end
   end

   assign has_item = COUNT_W'(cursor_ff) < count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset && (!rsp_valid_ff || rsp_tready);
         end
         ST_RESULT: begin
            load_rsp = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[31:0]  = has_item ? OUT_ITEM_W'(cursor_word) : '0;
      rsp_data_in[32]    = has_item;
      rsp_data_in[38:33] = OUT_COUNT_W'(count_ff);
      rsp_data_in[43:39] = OUT_CURSOR_W'(cursor_ff);
      rsp_data_in[75:44] = rd_en_ff ? OUT_ITEM_W'(read_word) : '0;
      rsp_data_in[76]    = err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            count_ff  <= ctrl.count_next;
            cursor_ff <= ctrl.cursor_next;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff   <= ctrl.err;
         rd_en_ff <= ctrl.rd_en;
         index_ff <= req_tdata[36 +: SLOT_IDX_W];
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// File: rtl/csb_checker.sv
// Port-level checks for the cursor sequence buffer, bound to the top level.
`default_nettype none
module csb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [csb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import csb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Response changed while stalled.");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("No response two cycles after a request transfer.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request taken while the previous operation is in progress.");

   a_valid_matches_cursor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32] == ({1'b0, rsp_tdata[43:39]} < rsp_tdata[38:33]))
                     && (rsp_tdata[38:33] <= OUT_COUNT_W'(CAPACITY_SLOTS)))
      else $error("Item valid flag disagrees with cursor and count.");

   a_error_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[76] |-> rsp_tdata[75:44] == '0)
      else $error("Read data reported on a failed operation.");

endmodule

bind cursor_sequence_buffer_core csb_checker u_csb_checker (.*);
`default_nettype wire
